/* sv/peeq_pkg.sv */
`timescale 1ns / 1ps
package peeq_pkg;

    localparam int DepthDefault = 16;

    localparam logic [1:0] KindLearning = 2'd1;
    localparam logic [1:0] KindBackfill = 2'd2;

    localparam logic [1:0] PrioLow       = 2'd0;
    localparam logic [1:0] PrioImportant = 2'd1;
    localparam logic [1:0] PrioCritical  = 2'd2;

    localparam logic [2:0] ActAppend     = 3'd0;
    localparam logic [2:0] ActCoalesce   = 3'd1;
    localparam logic [2:0] ActEvictLow   = 3'd2;
    localparam logic [2:0] ActEvictImp   = 3'd3;
    localparam logic [2:0] ActEvictCrit  = 3'd4;
    localparam logic [2:0] ActDrainEntry = 3'd5;
    localparam logic [2:0] ActDrainEmpty = 3'd6;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  op_kind;
        logic        success;
        logic        should_remember;
        logic        save_ok;
        logic        was_added;
        logic        embed_err;
        logic [63:0] turn_id;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  victim_kind;
        logic [1:0]  out_kind;
        logic [4:0]  out_flags;
        logic [63:0] out_turn;
        logic [15:0] out_coalesced;
        logic        last;
        logic [4:0]  queue_level;
        logic [31:0] dropped_total;
        logic [31:0] coalesced_total;
        logic [31:0] critical_evicted_total;
    } t_out_res;

    // one queue entry: kind in [6:5], flags in [4:0]
    typedef struct packed {
        logic [63:0] turn;
        logic [6:0]  kf;
        logic [15:0] coal;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic shift;      // cells at or above sel take neighbor above
        logic load;       // cell at wr_idx takes new entry
        logic fold;       // cell at wr_idx coalesces
        logic drain;      // every cell takes neighbor above
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_DRAIN,
        S_OUT
    } t_state;

    function automatic logic [1:0] rank_of(input logic [6:0] kf);
        logic [1:0] kind;
        kind = kf[6:5];
        if (kind == KindBackfill)
            return (!kf[0] || !kf[2]) ? PrioCritical : PrioLow;
        if (kind == KindLearning)
            return (kf[2] && !kf[4]) ? PrioImportant : PrioCritical;
        if (!kf[0] || (kf[1] && !kf[2]))
            return PrioCritical;
        if (kf[1] && kf[3])
            return PrioImportant;
        return PrioLow;
    endfunction

    function automatic logic foldable(input logic [6:0] kf);
        return kf[6:5] == KindBackfill && kf[0] && kf[2];
    endfunction

endpackage

/* sv/peeq_cell.sv */
`timescale 1ns / 1ps
module peeq_cell (
    input  logic              i_clk,
    input  peeq_pkg::t_cell_ctl i_ctl,
    input  logic              i_at_or_above,
    input  logic              i_is_wr,
    input  peeq_pkg::t_entry  i_up,
    input  peeq_pkg::t_entry  i_new,
    output peeq_pkg::t_entry  o_ent,
    output logic [1:0]        o_rank
);
    import peeq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic [15:0] w_c;

    always_comb begin
        n_ent = r_ent;
        w_c   = (r_ent.coal == 16'd0) ? 16'd1 : r_ent.coal;
        if (i_ctl.drain || (i_ctl.shift && i_at_or_above)) begin
            n_ent = i_up;
        end else if (i_ctl.load && i_is_wr) begin
            n_ent = i_new;
        end else if (i_ctl.fold && i_is_wr) begin
            n_ent.turn = i_new.turn;
            n_ent.coal = (w_c == 16'hFFFF) ? w_c : w_c + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent  = r_ent;
    assign o_rank = rank_of(r_ent.kf);
endmodule

/* sv/peeq_ctrl.sv */
`timescale 1ns / 1ps
module peeq_ctrl #(
    parameter int DEPTH = peeq_pkg::DepthDefault,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  peeq_pkg::t_in_req    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output peeq_pkg::t_out_res   o_out_data,
    input  peeq_pkg::t_entry     i_head,
    input  logic [DEPTH*2-1:0]   i_ranks,
    input  logic [6:0]           i_tail_kf,
    input  logic [1:0]           i_sel_kind,
    output peeq_pkg::t_cell_ctl  o_ctl,
    output logic [IW-1:0]        o_sel,
    output logic [IW-1:0]        o_wr_idx,
    output peeq_pkg::t_entry     o_new
);
    import peeq_pkg::*;

    t_state r_state, n_state;
    logic [4:0]    r_maxp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_left, n_left;
    logic [IW-1:0] r_sel, n_sel;
    logic [31:0]   r_drop, n_drop, r_coal, n_coal, r_crit, n_crit;
    t_in_req       r_req;
    t_out_res      r_out, n_out;
    t_out_res      r_res, n_res;
    logic          r_ov, n_ov;
    logic [CW-1:0] w_lim;
    logic          w_lo_f, w_im_f;
    logic [IW-1:0] w_lo_i, w_im_i;
    logic [6:0]    w_kf;
    logic          w_acc;

    assign w_kf = {r_req.op_kind, r_req.embed_err, r_req.was_added,
                   r_req.save_ok, r_req.should_remember, r_req.success};

    always_comb begin
        if (r_maxp == 5'd0)
            w_lim = CW'(1);
        else if (32'(r_maxp) > DEPTH)
            w_lim = CW'(DEPTH);
        else
            w_lim = CW'(r_maxp);
    end

    // oldest low / important entry among occupied slots
    always_comb begin
        w_lo_f = 1'b0;
        w_im_f = 1'b0;
        w_lo_i = '0;
        w_im_i = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (CW'(k) < r_cnt) begin
                if (i_ranks[k*2 +: 2] == PrioLow) begin
                    w_lo_f = 1'b1;
                    w_lo_i = IW'(k);
                end
                if (i_ranks[k*2 +: 2] == PrioImportant) begin
                    w_im_f = 1'b1;
                    w_im_i = IW'(k);
                end
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_maxp  <= 5'd16;
            r_cnt   <= '0;
            r_left  <= '0;
            r_sel   <= '0;
            r_drop  <= '0;
            r_coal  <= '0;
            r_crit  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we)
                r_maxp <= i_cfg_wdata;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_sel   <= n_sel;
            r_drop  <= n_drop;
            r_coal  <= n_coal;
            r_crit  <= n_crit;
            r_ov    <= n_ov;
        end
    end

    // r_res builds the result while r_out may still hold the previous one
    always_ff @(posedge i_clk) begin
        if (w_acc)
            r_req <= i_in_data;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_sel   = r_sel;
        n_drop  = r_drop;
        n_coal  = r_coal;
        n_crit  = r_crit;
        n_ov    = r_ov;
        n_out   = r_out;
        n_res   = r_res;
        o_ctl   = '0;
        o_sel   = r_sel;
        o_wr_idx = IW'(r_cnt - CW'(1));
        o_new.turn = r_req.turn_id;
        o_new.kf   = w_kf;
        o_new.coal = 16'd0;
        if (r_ov && !i_out_stall)
            n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc)
                    n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_res = '0;
                if (r_req.req_type) begin
                    if (r_cnt == '0) begin
                        n_res.action = ActDrainEmpty;
                        n_res.last   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_left  = r_cnt;
                        n_cnt   = '0;
                        n_state = S_DRAIN;
                    end
                end else if (r_cnt < w_lim) begin
                    n_res.action = ActAppend;
                    n_state = S_WRITE;
                end else if (foldable(w_kf) && r_cnt != '0 && foldable(i_tail_kf)) begin
                    o_ctl.fold = 1'b1;
                    n_coal = (r_coal == '1) ? r_coal : r_coal + 32'd1;
                    n_res.action = ActCoalesce;
                    n_res.last   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    if (w_lo_f) begin
                        n_sel = w_lo_i;
                        n_res.action = ActEvictLow;
                    end else if (w_im_f) begin
                        n_sel = w_im_i;
                        n_res.action = ActEvictImp;
                    end else begin
                        n_sel = '0;
                        n_res.action = ActEvictCrit;
                    end
                    if (w_lo_f || w_im_f)
                        n_drop = (r_drop == '1) ? r_drop : r_drop + 32'd1;
                    else
                        n_crit = (r_crit == '1) ? r_crit : r_crit + 32'd1;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // compaction: entries above the victim move down one slot
                n_res.victim_kind = i_sel_kind;
                o_ctl.shift = 1'b1;
                n_cnt   = r_cnt - CW'(1);
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_wr_idx   = IW'(r_cnt);
                o_ctl.load = 1'b1;
                n_cnt      = r_cnt + CW'(1);
                n_res.last = 1'b1;
                n_state    = S_OUT;
            end
            S_DRAIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_out = '0;
                    n_out.action        = ActDrainEntry;
                    n_out.out_kind      = i_head.kf[6:5];
                    n_out.out_flags     = i_head.kf[4:0];
                    n_out.out_turn      = i_head.turn;
                    n_out.out_coalesced = i_head.coal;
                    n_out.last          = (r_left == CW'(1));
                    n_out.dropped_total          = r_drop;
                    n_out.coalesced_total        = r_coal;
                    n_out.critical_evicted_total = r_crit;
                    n_ov        = 1'b1;
                    o_ctl.drain = 1'b1;
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1))
                        n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out = r_res;
                    n_out.queue_level            = 5'(r_cnt);
                    n_out.dropped_total          = r_drop;
                    n_out.coalesced_total        = r_coal;
                    n_out.critical_evicted_total = r_crit;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("level above depth");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_state == S_DECIDE) else $error("accept did not start");
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_cnt == '0) else $error("drain left entries");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> (r_ov && $stable(r_out)))
        else $error("stalled result changed");
endmodule

/* sv/priority_evicting_event_queue_top.sv */
`timescale 1ns / 1ps
// Bounded event queue with priority eviction.
// Input channel: i_in_valid / o_in_stall carries one request (admit or drain).
// Output channel: o_out_valid / i_out_stall carries result items.
// One request is handled at a time; o_in_stall is high while it is in work.
// Admit: DECIDE, then WRITE, then OUT registers one result with last set;
// with an eviction, SHIFT comes before WRITE and moves the cell row down
// past the victim. Coalesce and drain of an empty queue go from DECIDE
// straight to OUT. Drain: one result per entry, one per cycle while the
// output is not stalled, from the head cell as the row shifts toward slot
// 0; last marks the final entry. Accepting the next request waits until
// the final result is registered.
// Results wait in an output register; a stalled receiver holds the row.
// i_cfg_we writes max_pending (bound); write only while idle.
// Reset (synchronous, i_rst_n low) empties the queue, clears counters and
// sets the bound to 16. Entry storage is not cleared.
module priority_evicting_event_queue_top #(
    parameter int DEPTH = peeq_pkg::DepthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  peeq_pkg::t_in_req   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output peeq_pkg::t_out_res  o_out_data
);
    import peeq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cell_ctl          w_ctl;
    logic [IW-1:0]      w_sel, w_wr;
    t_entry             w_new;
    t_entry             w_ent [DEPTH];
    logic [DEPTH*2-1:0] w_ranks;
    logic [6:0]         w_tail_kf;
    logic [1:0]         w_sel_kind;

    always_comb begin
        w_tail_kf  = w_ent[0].kf;
        w_sel_kind = w_ent[0].kf[6:5];
        for (int k = 0; k < DEPTH; k++) begin
            if (IW'(k) == w_wr)
                w_tail_kf = w_ent[k].kf;
            if (IW'(k) == w_sel)
                w_sel_kind = w_ent[k].kf[6:5];
        end
    end

    peeq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_head(w_ent[0]), .i_ranks(w_ranks), .i_tail_kf(w_tail_kf),
        .i_sel_kind(w_sel_kind),
        .o_ctl(w_ctl), .o_sel(w_sel), .o_wr_idx(w_wr), .o_new(w_new)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_up;
        if (g == DEPTH - 1) begin : g_end
            assign w_up = w_ent[g];
        end else begin : g_mid
            assign w_up = w_ent[g+1];
        end
        peeq_cell u_cell (
            .i_clk(i_clk), .i_ctl(w_ctl),
            .i_at_or_above(IW'(g) >= w_sel),
            .i_is_wr(IW'(g) == w_wr),
            .i_up(w_up), .i_new(w_new),
            .o_ent(w_ent[g]), .o_rank(w_ranks[g*2 +: 2])
        );
    end
endmodule
